// ===== design/vff_pkg.sv =====
// Package for the viscous face flux block: payload structs, stage-to-stage
// structs, fixed-point widths and the small arithmetic helpers.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package vff_pkg;

  // Field widths of the external payload.
  localparam int COMP_W   = 16;              // signed Q8.8 vector component
  localparam int NCOMP    = 3;
  localparam int VEC_W    = NCOMP * COMP_W;
  localparam int AREA_W   = 16;
  localparam int TEMP_W   = 16;
  localparam int COEF_W   = 24;              // unsigned Q0.24 coefficient
  localparam int FLUX_W   = 40;              // signed Q24.16 result

  // Internal widths, sized from the value ranges of the datapath.
  localparam int STRESS_W    = 20;                       // three times the stress
  localparam int AVEC_W      = COMP_W + AREA_W + 1;      // area vector, Q.16
  localparam int MOM_W       = 52;                       // S_k . A, Q.24
  localparam int RND_SHIFT   = 8;
  localparam int RES_W       = MOM_W - RND_SHIFT;        // M_k rounded to Q.16
  localparam int VPROD_W     = COMP_W + RES_W;
  localparam int WORK_W      = 62;
  localparam int MAG_W       = WORK_W - 1;
  localparam int SPLIT       = 31;
  localparam int LO_PP_W     = SPLIT + COEF_W;
  localparam int HI_PP_W     = MAG_W - SPLIT + COEF_W;
  localparam int FULL_W      = MAG_W + COEF_W;
  localparam int SCALE_SHIFT = 32;
  localparam int HI_W        = FULL_W - SCALE_SHIFT;
  localparam int QUOT_LOG2   = 40;
  localparam int DIVD_W      = QUOT_LOG2 + 2;
  localparam int DIG_W       = 4;
  localparam int NDIG        = 11;
  localparam int NDIG_HI     = 6;
  localparam int NDIG_LO     = NDIG - NDIG_HI;
  localparam int PAD_W       = NDIG * DIG_W;
  localparam int CT_W        = COEF_W + TEMP_W;
  localparam int CTA_W       = CT_W + AREA_W;
  localparam int COND_SHIFT  = 24;
  localparam int COND_W      = CTA_W - COND_SHIFT;
  localparam int SUM_W       = DIVD_W + 1;
  localparam int NLANE       = 4;
  localparam int LANE_E      = 3;              // lane that carries the stress work

  // Divide-by-three digit step: q = (v * 43) >> 7 is exact for v below 128.
  localparam int DIV3_DIVISOR = 3;
  localparam int DIV3_MUL     = 43;
  localparam int DIV3_SH      = 7;
  localparam int DIV3_PROD_W  = 11;
  localparam int DIV3_V_W     = DIG_W + 2;

  localparam logic [FULL_W-1:0] SCALE_BIAS = FULL_W'(3) << (SCALE_SHIFT - 1);
  localparam logic [HI_W-1:0]   QUOT_CLAMP = HI_W'(3) << QUOT_LOG2;
  localparam logic signed [DIVD_W-1:0] QUOT_LIMIT = DIVD_W'(1) << QUOT_LOG2;
  localparam logic [CTA_W-1:0]  COND_BIAS  = CTA_W'(1) << (COND_SHIFT - 1);
  localparam logic signed [SUM_W-1:0] FLUX_MAX =
    (SUM_W'(1) << (FLUX_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] FLUX_MIN = -(SUM_W'(1) << (FLUX_W - 1));

  typedef logic signed [COMP_W-1:0]   comp_t;
  typedef logic signed [STRESS_W-1:0] stress_t;
  typedef logic signed [AVEC_W-1:0]   avec_t;
  typedef logic signed [MOM_W-1:0]    mom_t;
  typedef logic signed [RES_W-1:0]    res_t;
  typedef logic signed [VPROD_W-1:0]  vprod_t;
  typedef logic signed [WORK_W-1:0]   work_t;
  typedef logic        [MAG_W-1:0]    mag_t;
  typedef logic signed [DIVD_W-1:0]   quot_t;
  typedef logic signed [FLUX_W-1:0]   flux_t;
  typedef logic        [COEF_W-1:0]   coef_t;
  typedef logic        [COND_W-1:0]   cond_t;

  typedef enum logic [0:0] {
    REG_VISCOSITY    = 1'b0,
    REG_CONDUCTIVITY = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [VEC_W-1:0]  grad_u;
    logic [VEC_W-1:0]  grad_v;
    logic [VEC_W-1:0]  grad_w;
    logic [VEC_W-1:0]  unit_normal;
    logic [AREA_W-1:0] face_area;
    logic [VEC_W-1:0]  face_velocity;
    logic [TEMP_W-1:0] face_temperature;
  } in_req_t;

  typedef struct packed {
    flux_t momentum_flux_x;
    flux_t momentum_flux_y;
    flux_t momentum_flux_z;
    flux_t energy_flux;
  } out_req_t;

  // Stress front end to work stage.
  typedef struct packed {
    mom_t  [NCOMP-1:0] m;
    comp_t [NCOMP-1:0] v;
    cond_t             cond;
  } fw_t;

  // Work stage to coefficient scaling.
  typedef struct packed {
    work_t [NLANE-1:0] x;
    cond_t             cond;
  } ws_t;

  // Coefficient scaling to output stage.
  typedef struct packed {
    quot_t [NLANE-1:0] q;
    cond_t             cond;
  } sq_t;

  typedef struct packed {
    logic [DIG_W-1:0] q;
    logic [1:0]       r;
  } d3_t;

  function automatic comp_t vec_comp(logic [VEC_W-1:0] vec, int idx);
    return vec[idx*COMP_W +: COMP_W];
  endfunction

  // One radix-16 step of a long division by three.
  function automatic d3_t div3_step(logic [1:0] rem, logic [DIG_W-1:0] dig);
    logic [DIV3_V_W-1:0]    v;
    logic [DIV3_PROD_W-1:0] p;
    d3_t                    res;
    v     = {rem, dig};
    p     = DIV3_PROD_W'(v) * DIV3_PROD_W'(DIV3_MUL);
    res.q = p[DIV3_SH +: DIG_W];
    res.r = 2'(v - DIV3_V_W'(res.q) * DIV3_V_W'(DIV3_DIVISOR));
    return res;
  endfunction

  function automatic flux_t sat_flux(logic signed [SUM_W-1:0] x);
    flux_t res;
    if (x > FLUX_MAX) begin
      res = FLUX_MAX[FLUX_W-1:0];
    end else if (x < FLUX_MIN) begin
      res = FLUX_MIN[FLUX_W-1:0];
    end else begin
      res = x[FLUX_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/vff_stress.sv =====
// Front end of the viscous face flux pipeline: stress tensor, area vector,
// row products S_k . A and the conduction term, in three register stages.
// Depends on vff_pkg.
`default_nettype none

module vff_stress (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire vff_pkg::in_req_t  in_data,
  input  wire vff_pkg::coef_t    cond_coef,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output vff_pkg::fw_t           out_data
);

  localparam int NST = 3;
  localparam int NS  = 6;
  // Stress entries are stored as xx, yy, zz, xy, xz, yz.
  localparam int SIDX [3][3] = '{'{0, 3, 4}, '{3, 1, 5}, '{4, 5, 2}};

  logic [NST-1:0] vld_r, vld_nxt;
  logic [NST:0]   adv;

  vff_pkg::comp_t   gu [3], gv [3], gw [3], nrm [3];
  vff_pkg::stress_t osum [3];

  vff_pkg::stress_t s1_r [NS], s1_nxt [NS];
  vff_pkg::avec_t   a1_r [3], a1_nxt [3];
  vff_pkg::comp_t   v1_r [3], v1_nxt [3];
  logic [vff_pkg::CT_W-1:0]   ct1_r, ct1_nxt;
  logic [vff_pkg::AREA_W-1:0] area1_r;

  vff_pkg::mom_t    p2_r [3][3], p2_nxt [3][3];
  vff_pkg::comp_t   v2_r [3];
  logic [vff_pkg::CTA_W-1:0]  cta2_r, cta2_nxt, cta_b;

  vff_pkg::fw_t     out_r, out_nxt;

  always_comb begin
    adv[NST] = !out_stall;
    for (int k = NST - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NST; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  // Stage 1: unpack, area vector, three times the stress tensor and coefficient times temperature.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      gu[k]     = vff_pkg::vec_comp(in_data.grad_u, k);
      gv[k]     = vff_pkg::vec_comp(in_data.grad_v, k);
      gw[k]     = vff_pkg::vec_comp(in_data.grad_w, k);
      nrm[k]    = vff_pkg::vec_comp(in_data.unit_normal, k);
      v1_nxt[k] = vff_pkg::vec_comp(in_data.face_velocity, k);
      a1_nxt[k] = vff_pkg::avec_t'(nrm[k]) *
                  vff_pkg::avec_t'($signed({1'b0, in_data.face_area}));
    end
    s1_nxt[0] = (vff_pkg::stress_t'(gu[0]) <<< 2) - (vff_pkg::stress_t'(gv[1]) <<< 1)
              - (vff_pkg::stress_t'(gw[2]) <<< 1);
    s1_nxt[1] = (vff_pkg::stress_t'(gv[1]) <<< 2) - (vff_pkg::stress_t'(gu[0]) <<< 1)
              - (vff_pkg::stress_t'(gw[2]) <<< 1);
    s1_nxt[2] = (vff_pkg::stress_t'(gw[2]) <<< 2) - (vff_pkg::stress_t'(gu[0]) <<< 1)
              - (vff_pkg::stress_t'(gv[1]) <<< 1);
    osum[0]   = vff_pkg::stress_t'(gu[1]) + vff_pkg::stress_t'(gv[0]);
    osum[1]   = vff_pkg::stress_t'(gu[2]) + vff_pkg::stress_t'(gw[0]);
    osum[2]   = vff_pkg::stress_t'(gv[2]) + vff_pkg::stress_t'(gw[1]);
    for (int k = 0; k < 3; k++) begin
      s1_nxt[3+k] = (osum[k] <<< 1) + osum[k];
    end
    ct1_nxt = vff_pkg::CT_W'(cond_coef) * vff_pkg::CT_W'(in_data.face_temperature);
  end

  // Stage 2: the nine stress by area products and the conduction product.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        p2_nxt[k][j] = vff_pkg::mom_t'(s1_r[SIDX[k][j]]) * vff_pkg::mom_t'(a1_r[j]);
      end
    end
    cta2_nxt = vff_pkg::CTA_W'(ct1_r) * vff_pkg::CTA_W'(area1_r);
  end

  // Stage 3: row sums and the rounded conduction term.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      out_nxt.m[k] = p2_r[k][0] + p2_r[k][1] + p2_r[k][2];
      out_nxt.v[k] = v2_r[k];
    end
    cta_b        = cta2_r + vff_pkg::COND_BIAS;
    out_nxt.cond = cta_b[vff_pkg::CTA_W-1:vff_pkg::COND_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_r    <= s1_nxt;
      a1_r    <= a1_nxt;
      v1_r    <= v1_nxt;
      ct1_r   <= ct1_nxt;
      area1_r <= in_data.face_area;
    end
    if (adv[1]) begin
      p2_r   <= p2_nxt;
      v2_r   <= v1_r;
      cta2_r <= cta2_nxt;
    end
    if (adv[2]) begin
      out_r <= out_nxt;
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NST-1];
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== design/vff_work.sv =====
// Stress work stage of the viscous face flux pipeline: rounds each row
// product to Q.16, weights it by the face velocity and sums. Depends on vff_pkg.
`default_nettype none

module vff_work (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire vff_pkg::fw_t   in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output vff_pkg::ws_t        out_data
);

  localparam int NST = 3;
  localparam vff_pkg::mom_t RND_UP = vff_pkg::mom_t'(1) <<< (vff_pkg::RND_SHIFT - 1);
  localparam vff_pkg::mom_t RND_DN = RND_UP - vff_pkg::mom_t'(1);

  logic [NST-1:0] vld_r, vld_nxt;
  logic [NST:0]   adv;

  vff_pkg::mom_t   t [3];
  vff_pkg::res_t   r1_r [3], r1_nxt [3];
  vff_pkg::fw_t    d1_r, d2_r;
  vff_pkg::vprod_t p2_r [3], p2_nxt [3];
  vff_pkg::ws_t    out_r, out_nxt;

  always_comb begin
    adv[NST] = !out_stall;
    for (int k = NST - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NST; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  // Round to nearest with ties away from zero: a negative value takes one
  // less than half before the arithmetic shift.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t[k]      = in_data.m[k] + (in_data.m[k][vff_pkg::MOM_W-1] ? RND_DN : RND_UP);
      r1_nxt[k] = t[k][vff_pkg::MOM_W-1:vff_pkg::RND_SHIFT];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p2_nxt[k] = vff_pkg::vprod_t'($signed(d1_r.v[k])) * vff_pkg::vprod_t'(r1_r[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      out_nxt.x[k] = vff_pkg::work_t'($signed(d2_r.m[k]));
    end
    out_nxt.x[vff_pkg::LANE_E] = vff_pkg::work_t'(p2_r[0]) + vff_pkg::work_t'(p2_r[1])
                               + vff_pkg::work_t'(p2_r[2]);
    out_nxt.cond = d2_r.cond;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      r1_r <= r1_nxt;
      d1_r <= in_data;
    end
    if (adv[1]) begin
      p2_r <= p2_nxt;
      d2_r <= d1_r;
    end
    if (adv[2]) begin
      out_r <= out_nxt;
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NST-1];
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== design/vff_scale.sv =====
// Viscosity scaling for four lanes: round(|x| * c / (3 * 2^32)) with the sign
// restored, as split multiply, bias and shift, then a two-stage divide by three.
// Depends on vff_pkg.
`default_nettype none

module vff_scale (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire vff_pkg::ws_t    in_data,
  input  wire vff_pkg::coef_t  visc_coef,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output vff_pkg::sq_t         out_data
);

  localparam int NST  = 5;
  localparam int NL   = vff_pkg::NLANE;
  localparam int QH_W = vff_pkg::NDIG_HI * vff_pkg::DIG_W;
  localparam int QL_W = vff_pkg::NDIG_LO * vff_pkg::DIG_W;

  logic [NST-1:0] vld_r, vld_nxt;
  logic [NST:0]   adv;

  vff_pkg::work_t xs [NL];
  vff_pkg::mag_t  mag1_r [NL], mag1_nxt [NL];
  logic [NL-1:0]  sgn1_r, sgn2_r, sgn3_r, sgn4_r;
  vff_pkg::cond_t cond1_r, cond2_r, cond3_r, cond4_r;

  logic [vff_pkg::LO_PP_W-1:0] lo2_r [NL], lo2_nxt [NL];
  logic [vff_pkg::HI_PP_W-1:0] hi2_r [NL], hi2_nxt [NL];

  logic [vff_pkg::FULL_W-1:0]  full [NL];
  logic [vff_pkg::HI_W-1:0]    hi [NL];
  logic [vff_pkg::DIVD_W-1:0]  divd3_r [NL], divd3_nxt [NL];

  logic [vff_pkg::PAD_W-1:0]   pad [NL];
  vff_pkg::d3_t                st_hi [NL], st_lo [NL];
  logic [1:0]                  rem [NL], rem4_r [NL], rem4_nxt [NL], rem5 [NL];
  logic [QH_W-1:0]             qhi4_r [NL], qhi4_nxt [NL];
  logic [QL_W-1:0]             low4_r [NL], qlo [NL];
  logic [vff_pkg::DIVD_W-1:0]  qmag [NL];

  vff_pkg::sq_t   out_r, out_nxt;
  logic           rem_ok, q_ok;

  always_comb begin
    adv[NST] = !out_stall;
    for (int k = NST - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NST; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  // Stage 1: magnitude and sign.
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      xs[l]       = $signed(in_data.x[l]);
      mag1_nxt[l] = xs[l][vff_pkg::WORK_W-1] ? vff_pkg::MAG_W'(-xs[l])
                                            : vff_pkg::MAG_W'(xs[l]);
    end
  end

  // Stage 2: magnitude times coefficient as two partial products.
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      lo2_nxt[l] = vff_pkg::LO_PP_W'(mag1_r[l][vff_pkg::SPLIT-1:0]) *
                   vff_pkg::LO_PP_W'(visc_coef);
      hi2_nxt[l] = vff_pkg::HI_PP_W'(mag1_r[l][vff_pkg::MAG_W-1:vff_pkg::SPLIT]) *
                   vff_pkg::HI_PP_W'(visc_coef);
    end
  end

  // Stage 3: recombine, add 1.5 * 2^32 and drop 32 bits. Dividends that would
  // give a quotient of 2^40 or more are pinned there; every result that far
  // out saturates downstream anyway.
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      full[l] = vff_pkg::FULL_W'({hi2_r[l], {vff_pkg::SPLIT{1'b0}}})
              + vff_pkg::FULL_W'(lo2_r[l]) + vff_pkg::SCALE_BIAS;
      hi[l]   = full[l][vff_pkg::FULL_W-1:vff_pkg::SCALE_SHIFT];
      divd3_nxt[l] = (hi[l] >= vff_pkg::QUOT_CLAMP)
                   ? vff_pkg::DIVD_W'(vff_pkg::QUOT_CLAMP)
                   : vff_pkg::DIVD_W'(hi[l]);
    end
  end

  // Stage 4: upper quotient digits.
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      pad[l] = vff_pkg::PAD_W'(divd3_r[l]);
      rem[l] = 2'd0;
      qhi4_nxt[l] = '0;
      for (int i = 0; i < vff_pkg::NDIG_HI; i++) begin
        st_hi[l] = vff_pkg::div3_step(rem[l],
                     pad[l][vff_pkg::PAD_W-1-i*vff_pkg::DIG_W -: vff_pkg::DIG_W]);
        qhi4_nxt[l][(vff_pkg::NDIG_HI-1-i)*vff_pkg::DIG_W +: vff_pkg::DIG_W] = st_hi[l].q;
        rem[l] = st_hi[l].r;
      end
      rem4_nxt[l] = rem[l];
    end
  end

  // Stage 5: lower quotient digits and sign.
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      rem5[l] = rem4_r[l];
      qlo[l]  = '0;
      for (int i = 0; i < vff_pkg::NDIG_LO; i++) begin
        st_lo[l] = vff_pkg::div3_step(rem5[l],
                     low4_r[l][QL_W-1-i*vff_pkg::DIG_W -: vff_pkg::DIG_W]);
        qlo[l][(vff_pkg::NDIG_LO-1-i)*vff_pkg::DIG_W +: vff_pkg::DIG_W] = st_lo[l].q;
        rem5[l] = st_lo[l].r;
      end
      qmag[l]      = vff_pkg::DIVD_W'({qhi4_r[l], qlo[l]});
      out_nxt.q[l] = sgn4_r[l] ? -qmag[l] : qmag[l];
    end
    out_nxt.cond = cond4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      mag1_r  <= mag1_nxt;
      for (int l = 0; l < NL; l++) begin
        sgn1_r[l] <= in_data.x[l][vff_pkg::WORK_W-1];
      end
      cond1_r <= in_data.cond;
    end
    if (adv[1]) begin
      lo2_r   <= lo2_nxt;
      hi2_r   <= hi2_nxt;
      sgn2_r  <= sgn1_r;
      cond2_r <= cond1_r;
    end
    if (adv[2]) begin
      divd3_r <= divd3_nxt;
      sgn3_r  <= sgn2_r;
      cond3_r <= cond2_r;
    end
    if (adv[3]) begin
      qhi4_r  <= qhi4_nxt;
      rem4_r  <= rem4_nxt;
      for (int l = 0; l < NL; l++) begin
        low4_r[l] <= pad[l][QL_W-1:0];
      end
      sgn4_r  <= sgn3_r;
      cond4_r <= cond3_r;
    end
    if (adv[4]) begin
      out_r <= out_nxt;
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NST-1];
  assign out_data  = out_r;

  always_comb begin
    rem_ok = 1'b1;
    q_ok   = 1'b1;
    for (int l = 0; l < NL; l++) begin
      if (rem4_r[l] == 2'd3) begin
        rem_ok = 1'b0;
      end
      if ($signed(out_r.q[l]) > vff_pkg::QUOT_LIMIT ||
          $signed(out_r.q[l]) < -vff_pkg::QUOT_LIMIT) begin
        q_ok = 1'b0;
      end
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> rem_ok)
    else $error("divide-by-three remainder out of range");

  a_quot_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> q_ok)
    else $error("scaled value exceeds the clamp bound");

endmodule

`default_nettype wire

// ===== design/viscous_face_flux_top.sv =====
// Top level of the viscous face flux block: configuration registers, the
// three pipeline sections and the saturating output register.
// Depends on vff_pkg, vff_stress, vff_work and vff_scale.
//
// Usage: one face request enters on in_valid/in_stall/in_data and one flux
// request leaves on out_valid/out_stall/out_data. A request moves at a rising
// edge where valid is high and stall is low. The block has no memory between
// faces, so a new face may enter on every cycle.
// Throughput is one face per cycle while out_stall is low. A face passes 12
// register stages: three for the stress and area products, three for the
// stress work, five for the viscosity scaling and its divide by three, and
// one output register where the results are saturated to Q24.16.
// Viscosity and conductivity are written through cfg_we/cfg_index/cfg_data
// and should only change while no face is in flight.
// Reset (rst_n low at a clock edge) empties every stage and clears both
// coefficients to zero. When the receiver holds out_stall, each stage keeps
// filling until it meets a full stage ahead of it; in_stall rises only once
// every stage holds a face, and nothing is dropped or repeated.
`default_nettype none

module viscous_face_flux_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire vff_pkg::in_req_t    in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output vff_pkg::out_req_t        out_data,
  input  wire logic                cfg_we,
  input  wire vff_pkg::cfg_reg_t   cfg_index,
  input  wire vff_pkg::coef_t      cfg_data
);

  vff_pkg::coef_t visc_r, cond_coef_r;

  logic         fw_valid, fw_stall;
  vff_pkg::fw_t fw_data;
  logic         ws_valid, ws_stall;
  vff_pkg::ws_t ws_data;
  logic         sq_valid, sq_stall;
  vff_pkg::sq_t sq_data;

  logic                          out_vld_r, out_adv;
  vff_pkg::out_req_t             res_r, res_nxt;
  logic signed [vff_pkg::SUM_W-1:0] esum;

  // Coefficient registers. Both only feed the datapath; an index outside the
  // list leaves them alone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visc_r      <= '0;
      cond_coef_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vff_pkg::REG_VISCOSITY:    visc_r      <= cfg_data;
        vff_pkg::REG_CONDUCTIVITY: cond_coef_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stress tensor, area vector, row products and conduction term.
  vff_stress u_stress (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cond_coef (cond_coef_r),
    .out_valid (fw_valid),
    .out_stall (fw_stall),
    .out_data  (fw_data)
  );

  // Velocity-weighted stress work; momentum rows ride alongside.
  vff_work u_work (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fw_valid),
    .in_stall  (fw_stall),
    .in_data   (fw_data),
    .out_valid (ws_valid),
    .out_stall (ws_stall),
    .out_data  (ws_data)
  );

  // Viscosity scaling of the three momentum rows and the work, side by side.
  vff_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ws_valid),
    .in_stall  (ws_stall),
    .in_data   (ws_data),
    .visc_coef (visc_r),
    .out_valid (sq_valid),
    .out_stall (sq_stall),
    .out_data  (sq_data)
  );

  // Output register: saturate the momentum rows, and add the conduction
  // term to the stress work before its own saturation.
  always_comb begin
    res_nxt.momentum_flux_x =
      vff_pkg::sat_flux(vff_pkg::SUM_W'($signed(sq_data.q[0])));
    res_nxt.momentum_flux_y =
      vff_pkg::sat_flux(vff_pkg::SUM_W'($signed(sq_data.q[1])));
    res_nxt.momentum_flux_z =
      vff_pkg::sat_flux(vff_pkg::SUM_W'($signed(sq_data.q[2])));
    esum = vff_pkg::SUM_W'($signed(sq_data.q[vff_pkg::LANE_E]))
         + vff_pkg::SUM_W'(sq_data.cond);
    res_nxt.energy_flux = vff_pkg::sat_flux(esum);
  end

  assign out_adv  = !out_vld_r || !out_stall;
  assign sq_stall = !out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = res_r;

  // Input backpressure can only come from a stalled, occupied output.
  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output is free");

endmodule

`default_nettype wire

// ===== verif/viscous_face_flux_top_tb.sv =====
// Self-checking testbench for viscous_face_flux_top: face requests are driven from a queue,
// flux requests are checked field by field against an in-bench fixed-point predictor.
// Depends on vff_pkg for the payload structs, coefficient type and register names.
`timescale 1ns / 100ps

module viscous_face_flux_top_tb;

  localparam int     CLK_PERIOD    = 10;
  localparam int     RESET_CYCLES  = 11;
  localparam int     PIPE_LATENCY  = 12;
  localparam int     WATCHDOG_MAX  = 4000;
  localparam int     LONG_HOLD     = 120;
  localparam int     HOLD_SPACING  = 500;
  localparam int     PHASE_FACES   = 148;
  localparam int     NUM_PHASES    = 7;
  localparam longint FLUX_TOP      = (64'sd1 <<< (vff_pkg::FLUX_W - 1)) - 1;
  localparam longint FLUX_BOTTOM   = -(64'sd1 <<< (vff_pkg::FLUX_W - 1));
  localparam vff_pkg::coef_t COEF_FULL = 24'hFFFFFF;

  // DUT ports. Every input has a known value from time zero.
  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  vff_pkg::in_req_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  vff_pkg::out_req_t out_data;
  logic              cfg_we    = 1'b0;
  vff_pkg::cfg_reg_t cfg_index = vff_pkg::REG_VISCOSITY;
  vff_pkg::coef_t    cfg_data  = '0;

  // Faces waiting to be offered, and flux requests waiting to come back.
  vff_pkg::in_req_t  face_queue[$];
  vff_pkg::out_req_t flux_expect[$];

  // Shadow copy of the two coefficient registers, updated at the write edge.
  vff_pkg::coef_t visc_coeff = '0;
  vff_pkg::coef_t cond_coeff = '0;

  int unsigned faces_loaded   = 0;
  int unsigned faces_accepted = 0;
  int unsigned fluxes_checked = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;

  // Sender and receiver pacing state.
  logic        in_taken       = 1'b0;
  int          send_gap       = 0;
  int          send_calm      = 0;
  int          stall_left     = 0;
  int          recv_calm      = 0;
  int unsigned next_long_hold = 60;

  vff_pkg::out_req_t want;
  vff_pkg::flux_t    want_f;
  vff_pkg::flux_t    got_f;
  string             flux_name[4] = '{"momentum_flux_x", "momentum_flux_y",
                                      "momentum_flux_z", "energy_flux"};

  viscous_face_flux_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Flux predictor. The stress is carried at three times its value so that the
  // 2/3 dilatation terms stay in integers; the divide by three and the
  // viscosity scaling happen together at the end, rounded half away from zero.
  // ---------------------------------------------------------------------------

  // round(x * c / (3 * 2^32)), ties away from zero.
  function automatic longint scale_by_coeff(longint x, vff_pkg::coef_t c);
    logic [127:0] mag;
    logic [127:0] quo;
    mag = (x < 0) ? 128'(-x) : 128'(x);
    quo = (mag * 128'(c) + (128'd3 << 31)) / (128'd3 << 32);
    return (x < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  // Drop eight fraction bits, ties away from zero.
  function automatic longint round_drop8(longint x);
    longint mag;
    mag = (x < 0) ? -x : x;
    mag = (mag + 128) >> 8;
    return (x < 0) ? -mag : mag;
  endfunction

  function automatic vff_pkg::flux_t clamp_flux(longint x);
    if (x > FLUX_TOP) begin
      return vff_pkg::flux_t'(FLUX_TOP);
    end else if (x < FLUX_BOTTOM) begin
      return vff_pkg::flux_t'(FLUX_BOTTOM);
    end
    return vff_pkg::flux_t'(x);
  endfunction

  function automatic vff_pkg::out_req_t flux_predict(vff_pkg::in_req_t f);
    longint   gu[3], gv[3], gw[3], av[3], vel[3], mom[3];
    longint   tau3[3][3];
    longint   work;
    longint   energy;
    logic [63:0] cond_term;
    vff_pkg::out_req_t r;
    work = 0;
    for (int k = 0; k < 3; k++) begin
      gu[k]  = longint'($signed(f.grad_u[vff_pkg::COMP_W*k +: vff_pkg::COMP_W]));
      gv[k]  = longint'($signed(f.grad_v[vff_pkg::COMP_W*k +: vff_pkg::COMP_W]));
      gw[k]  = longint'($signed(f.grad_w[vff_pkg::COMP_W*k +: vff_pkg::COMP_W]));
      vel[k] = longint'($signed(f.face_velocity[vff_pkg::COMP_W*k +: vff_pkg::COMP_W]));
      // The normal is taken as it comes, with no renormalization.
      av[k]  = longint'($signed(f.unit_normal[vff_pkg::COMP_W*k +: vff_pkg::COMP_W]))
             * longint'(f.face_area);
    end
    tau3[0][0] = 2 * (2 * gu[0] - gv[1] - gw[2]);
    tau3[1][1] = 2 * (2 * gv[1] - gu[0] - gw[2]);
    tau3[2][2] = 2 * (2 * gw[2] - gu[0] - gv[1]);
    tau3[0][1] = 3 * (gu[1] + gv[0]);
    tau3[0][2] = 3 * (gu[2] + gw[0]);
    tau3[1][2] = 3 * (gv[2] + gw[1]);
    tau3[1][0] = tau3[0][1];
    tau3[2][0] = tau3[0][2];
    tau3[2][1] = tau3[1][2];
    for (int k = 0; k < 3; k++) begin
      mom[k] = tau3[k][0] * av[0] + tau3[k][1] * av[1] + tau3[k][2] * av[2];
      // Stress work uses each row product rounded to Q.16 first, ties away from zero.
      work  += vel[k] * round_drop8(mom[k]);
    end
    r.momentum_flux_x = clamp_flux(scale_by_coeff(mom[0], visc_coeff));
    r.momentum_flux_y = clamp_flux(scale_by_coeff(mom[1], visc_coeff));
    r.momentum_flux_z = clamp_flux(scale_by_coeff(mom[2], visc_coeff));
    cond_term = (64'(cond_coeff) * 64'(f.face_temperature) * 64'(f.face_area)
                 + 64'h80_0000) >> 24;
    // The conduction term is never negative; saturation is applied only to the sum.
    energy = scale_by_coeff(work, visc_coeff) + longint'(cond_term);
    r.energy_flux = clamp_flux(energy);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic logic [vff_pkg::VEC_W-1:0] vec3(logic [15:0] x, logic [15:0] y,
                                                     logic [15:0] z);
    return {z, y, x};
  endfunction

  // Gap length shared by sender and receiver: mostly none or short, a few long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One vector component: the rails, small physical values or anything at all.
  function automatic logic [15:0] pick_comp();
    int          r;
    logic [15:0] v;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      case ($urandom_range(0, 4))
        0:       v = 16'h8000;
        1:       v = 16'h7FFF;
        2:       v = 16'h0000;
        3:       v = 16'hFFFF;
        default: v = 16'h0001;
      endcase
    end else if (r < 55) begin
      v = 16'($urandom_range(0, 1024)) - 16'd512;
    end else begin
      v = 16'($urandom);
    end
    return v;
  endfunction

  function automatic logic [15:0] pick_scalar();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(0, 16'h0400));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_face(input logic [vff_pkg::VEC_W-1:0] gu, gv, gw, nrm,
                           input logic [15:0] area,
                           input logic [vff_pkg::VEC_W-1:0] vel,
                           input logic [15:0] temp);
    vff_pkg::in_req_t f;
    f.grad_u           = gu;
    f.grad_v           = gv;
    f.grad_w           = gw;
    f.unit_normal      = nrm;
    f.face_area        = area;
    f.face_velocity    = vel;
    f.face_temperature = temp;
    face_queue.push_back(f);
    faces_loaded++;
  endtask

  task automatic load_random_face();
    logic [vff_pkg::VEC_W-1:0] nrm;
    logic [15:0]               axis_val;
    if ($urandom_range(0, 3) == 0) begin
      // Raw noise over every bit of every field.
      load_face(vff_pkg::VEC_W'({$urandom, $urandom}),
                vff_pkg::VEC_W'({$urandom, $urandom}),
                vff_pkg::VEC_W'({$urandom, $urandom}),
                vff_pkg::VEC_W'({$urandom, $urandom}), 16'($urandom),
                vff_pkg::VEC_W'({$urandom, $urandom}), 16'($urandom));
    end else begin
      if ($urandom_range(0, 2) == 0) begin
        // Axis-aligned unit normal of either sign.
        axis_val = $urandom_range(0, 1) ? 16'h0100 : 16'hFF00;
        case ($urandom_range(0, 2))
          0:       nrm = vec3(axis_val, 16'h0, 16'h0);
          1:       nrm = vec3(16'h0, axis_val, 16'h0);
          default: nrm = vec3(16'h0, 16'h0, axis_val);
        endcase
      end else begin
        nrm = vec3(pick_comp(), pick_comp(), pick_comp());
      end
      load_face(vec3(pick_comp(), pick_comp(), pick_comp()),
                vec3(pick_comp(), pick_comp(), pick_comp()),
                vec3(pick_comp(), pick_comp(), pick_comp()),
                nrm, pick_scalar(),
                vec3(pick_comp(), pick_comp(), pick_comp()),
                pick_scalar());
    end
  endtask

  task automatic write_coeff(input vff_pkg::cfg_reg_t idx, input vff_pkg::coef_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Hold here until every loaded face has been taken and every flux has come back.
  task automatic wait_drained();
    while (!(faces_accepted == faces_loaded && flux_expect.size() == 0)) begin
      @(negedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender. It changes the request on the falling edge only, and only once the
  // current one has been taken at the rising edge before (in_taken).
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (face_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= face_queue.pop_front();
        // Calm stretches give back-to-back requests; otherwise draw a gap.
        if (send_calm > 0) begin
          send_calm <= send_calm - 1;
          send_gap  <= 0;
        end else begin
          send_gap <= idle_len();
          if ($urandom_range(0, 39) == 0) begin
            send_calm <= $urandom_range(20, 80);
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. Random stalls of mixed length, calm stretches without any, and a
  // long hold every few hundred results so the pipeline fills and in_stall rises
  // while the sender keeps offering faces.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (fluxes_checked >= next_long_hold) begin
      out_stall      <= 1'b1;
      stall_left     <= LONG_HOLD;
      next_long_hold <= next_long_hold + HOLD_SPACING;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (recv_calm > 0) begin
        recv_calm <= recv_calm - 1;
      end else if ($urandom_range(0, 59) == 0) begin
        recv_calm <= $urandom_range(30, 120);
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left <= idle_len() + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor on the rising edge: shadows register writes, checks each flux
  // request against the oldest prediction, predicts each accepted face, and
  // runs the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken   <= 1'b0;
      visc_coeff = '0;
      cond_coeff = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          vff_pkg::REG_VISCOSITY:    visc_coeff = cfg_data;
          vff_pkg::REG_CONDUCTIVITY: cond_coeff = cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (flux_expect.size() == 0) begin
          mismatches++;
          $display("%0t: flux request with no face outstanding: %h", $time, out_data);
        end else begin
          want = flux_expect.pop_front();
          fluxes_checked++;
          for (int k = 0; k < 4; k++) begin
            want_f = want[vff_pkg::FLUX_W*(3-k) +: vff_pkg::FLUX_W];
            got_f  = out_data[vff_pkg::FLUX_W*(3-k) +: vff_pkg::FLUX_W];
            if (want_f !== got_f) begin
              mismatches++;
              $display("%0t: result %0d %s expected %0d actual %0d", $time,
                       fluxes_checked, flux_name[k], want_f, got_f);
            end
          end
        end
      end

      if (in_valid && !in_stall) begin
        flux_expect.push_back(flux_predict(in_data));
        faces_accepted++;
      end
      in_taken <= in_valid && !in_stall;

      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("%0t: watchdog: no request moved for %0d cycles", $time, quiet_cycles);
        $display("viscous_face_flux_top_tb failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence. Coefficients only change with the pipeline empty, which also
  // makes the sender pause until every flux of the phase has come back.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed faces with both coefficients at full scale, so the rails saturate.
    write_coeff(vff_pkg::REG_VISCOSITY, COEF_FULL);
    write_coeff(vff_pkg::REG_CONDUCTIVITY, COEF_FULL);

    load_face('0, '0, '0, '0, 16'h0000, '0, 16'h0000);
    load_face(vec3(16'h7FFF, 16'h7FFF, 16'h7FFF), vec3(16'h7FFF, 16'h7FFF, 16'h7FFF),
              vec3(16'h7FFF, 16'h7FFF, 16'h7FFF), vec3(16'h7FFF, 16'h7FFF, 16'h7FFF),
              16'hFFFF, vec3(16'h7FFF, 16'h7FFF, 16'h7FFF), 16'hFFFF);
    load_face(vec3(16'h8000, 16'h8000, 16'h8000), vec3(16'h8000, 16'h8000, 16'h8000),
              vec3(16'h8000, 16'h8000, 16'h8000), vec3(16'h8000, 16'h8000, 16'h8000),
              16'hFFFF, vec3(16'h8000, 16'h8000, 16'h8000), 16'hFFFF);
    // Most negative x normal stress on a full-area face: negative saturation.
    load_face(vec3(16'h8000, 16'h0, 16'h0), vec3(16'h0, 16'h7FFF, 16'h0),
              vec3(16'h0, 16'h0, 16'h7FFF), vec3(16'h7FFF, 16'h0, 16'h0),
              16'hFFFF, vec3(16'h7FFF, 16'h8000, 16'h7FFF), 16'h0000);
    // Large stresses, positive but for yy and zz, with opposing velocity.
    load_face(vec3(16'h7FFF, 16'h7FFF, 16'h7FFF), vec3(16'h7FFF, 16'h8000, 16'h7FFF),
              vec3(16'h7FFF, 16'h7FFF, 16'h8000), vec3(16'h7FFF, 16'h7FFF, 16'h7FFF),
              16'hFFFF, vec3(16'h8000, 16'h8000, 16'h8000), 16'h0000);
    // Unit normals along each axis with unit area.
    load_face(vec3(16'h0100, 16'h0080, 16'hFF80), vec3(16'h0040, 16'hFF00, 16'h0020),
              vec3(16'h0010, 16'h0030, 16'h0200), vec3(16'h0100, 16'h0, 16'h0),
              16'h0100, vec3(16'h0100, 16'h0200, 16'hFF00), 16'h1234);
    load_face(vec3(16'h0100, 16'h0080, 16'hFF80), vec3(16'h0040, 16'hFF00, 16'h0020),
              vec3(16'h0010, 16'h0030, 16'h0200), vec3(16'h0, 16'h0100, 16'h0),
              16'h0100, vec3(16'h0100, 16'h0200, 16'hFF00), 16'h1234);
    load_face(vec3(16'h0100, 16'h0080, 16'hFF80), vec3(16'h0040, 16'hFF00, 16'h0020),
              vec3(16'h0010, 16'h0030, 16'h0200), vec3(16'h0, 16'h0, 16'hFF00),
              16'h0100, vec3(16'h0100, 16'h0200, 16'hFF00), 16'h1234);
    // Pure dilatation: the deviatoric stress, and so the momentum flux, is zero.
    load_face(vec3(16'h0100, 16'h0, 16'h0), vec3(16'h0, 16'h0100, 16'h0),
              vec3(16'h0, 16'h0, 16'h0100), vec3(16'h0100, 16'h0100, 16'h0100),
              16'h0200, vec3(16'h0100, 16'h0100, 16'h0100), 16'h0000);
    // Pure shear in all three planes.
    load_face(vec3(16'h0, 16'h0100, 16'h0080), vec3(16'h0100, 16'h0, 16'hFF80),
              vec3(16'h0080, 16'hFF80, 16'h0), vec3(16'h0100, 16'h0100, 16'h0),
              16'h0100, vec3(16'hFF00, 16'h0100, 16'h0080), 16'h0100);
    // Non-unit normal is used as it is.
    load_face(vec3(16'h0120, 16'hFFA0, 16'h0033), vec3(16'h0011, 16'h0150, 16'hFE00),
              vec3(16'h0070, 16'hFF10, 16'h0090), vec3(16'h0200, 16'h0300, 16'hFF00),
              16'h0180, vec3(16'h0050, 16'hFFB0, 16'h0120), 16'h2000);
    // Zero area with hot face: both conduction and momentum vanish.
    load_face(vec3(16'h7FFF, 16'h8000, 16'h1234), vec3(16'h4321, 16'h7FFF, 16'h8000),
              vec3(16'h0001, 16'hFFFF, 16'h7FFF), vec3(16'h7FFF, 16'h8000, 16'h7FFF),
              16'h0000, vec3(16'h7FFF, 16'h7FFF, 16'h7FFF), 16'hFFFF);
    // Conduction only: largest temperature times largest area.
    load_face('0, '0, '0, vec3(16'h0100, 16'h0, 16'h0), 16'hFFFF, '0, 16'hFFFF);
    // Row products exactly halfway when dropped to Q.16, positive and negative.
    load_face(vec3(16'h0, 16'h0001, 16'h0), '0, '0, vec3(16'h0080, 16'h0, 16'h0),
              16'h0001, vec3(16'h0, 16'h0100, 16'h0), 16'h0000);
    load_face(vec3(16'h0, 16'hFFFF, 16'h0), '0, '0, vec3(16'h0080, 16'h0, 16'h0),
              16'h0001, vec3(16'h0, 16'hFF00, 16'h0), 16'h0000);
    // Smallest nonzero magnitudes everywhere.
    load_face(vec3(16'h0001, 16'hFFFF, 16'h0001), vec3(16'hFFFF, 16'h0001, 16'hFFFF),
              vec3(16'h0001, 16'h0001, 16'hFFFF), vec3(16'h0001, 16'hFFFF, 16'h0001),
              16'h0001, vec3(16'hFFFF, 16'h0001, 16'h0001), 16'h0001);
    wait_drained();

    // Random phases, each under its own pair of coefficients.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1: begin
          write_coeff(vff_pkg::REG_VISCOSITY, COEF_FULL);
          write_coeff(vff_pkg::REG_CONDUCTIVITY, '0);
        end
        2: begin
          write_coeff(vff_pkg::REG_VISCOSITY, '0);
          write_coeff(vff_pkg::REG_CONDUCTIVITY, COEF_FULL);
        end
        3: begin
          write_coeff(vff_pkg::REG_VISCOSITY, vff_pkg::coef_t'(1));
          write_coeff(vff_pkg::REG_CONDUCTIVITY, vff_pkg::coef_t'(1));
        end
        4: begin
          write_coeff(vff_pkg::REG_VISCOSITY, vff_pkg::coef_t'($urandom_range(0, 4095)));
          write_coeff(vff_pkg::REG_CONDUCTIVITY, vff_pkg::coef_t'($urandom));
        end
        5: begin
          write_coeff(vff_pkg::REG_VISCOSITY, 24'h800000);
          write_coeff(vff_pkg::REG_CONDUCTIVITY, 24'h800000);
        end
        default: begin
          write_coeff(vff_pkg::REG_VISCOSITY, vff_pkg::coef_t'($urandom));
          write_coeff(vff_pkg::REG_CONDUCTIVITY, vff_pkg::coef_t'($urandom));
        end
      endcase
      repeat (PHASE_FACES) load_random_face();
      wait_drained();
    end

    // Any stray flux request in this window is caught by the monitor.
    repeat (2 * PIPE_LATENCY) @(negedge clk);
    if (mismatches == 0 && flux_expect.size() == 0) begin
      $display("viscous_face_flux_top_tb passed");
    end else begin
      $display("viscous_face_flux_top_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/vff_pkg.sv
design/vff_stress.sv
design/vff_work.sv
design/vff_scale.sv
design/viscous_face_flux_top.sv
verif/viscous_face_flux_top_tb.sv
